/* rtl/core/cnms_pkg.sv */
package cnms_pkg;

	// candidate storage
	localparam int MAX_BOXES    = 256;
	localparam int IDX_W        = $clog2(MAX_BOXES);
	localparam int CNT_W        = IDX_W + 1;

	// survivor list
	localparam int RESULT_LIMIT = 64;
	localparam int KA_W         = $clog2(RESULT_LIMIT);
	localparam int KCNT_W       = KA_W + 1;

	// configuration registers
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT       = CFG_IDX_W'(1);
	localparam logic [7:0] THR_RESET     = 8'd115;
	localparam logic [6:0] MAX_OUT_RESET = 7'd64;

	typedef struct packed {
		logic signed [11:0] box_left;
		logic signed [11:0] box_top;
		logic [10:0]        box_width;
		logic [10:0]        box_height;
		logic [6:0]         box_class;
		logic [15:0]        score;
		logic               last_box;
	} in_t;

	typedef struct packed {
		logic [7:0]         kept_index;
		logic signed [11:0] kept_left;
		logic signed [11:0] kept_top;
		logic [10:0]        kept_width;
		logic [10:0]        kept_height;
		logic [6:0]         kept_class;
		logic [15:0]        kept_score;
		logic               none_kept;
		logic               dropped_some;
		logic               last_result;
	} out_t;

	typedef struct packed {
		logic [6:0]         cls;
		logic [10:0]        height;
		logic [10:0]        width;
		logic signed [11:0] top;
		logic signed [11:0] left;
	} box_t;

	typedef struct packed {
		box_t        box;
		logic [15:0] score;
	} cand_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RK_RDI,
		ST_RK_LDI,
		ST_RK_RDJ,
		ST_RK_CMP,
		ST_SP_RANK,
		ST_SP_CAND,
		ST_SP_LOAD,
		ST_SP_KRD,
		ST_SP_A,
		ST_SP_B,
		ST_SP_C,
		ST_SP_D,
		ST_SP_E,
		ST_SURV,
		ST_FINISH
	} state_t;

endpackage

/* rtl/core/class_aware_nms_engine.sv */
// channel   | direction | handshake            | transaction
// ----------+-----------+----------------------+--------------------------------------
// in_data   | in        | in_valid / in_stall  | one candidate box, last_box ends batch
// out_data  | out       | out_valid / out_stall| one survivor or one none-kept result
// cfg       | in        | cfg_valid / cfg_ready| register write, index 0 thr, 1 max_out
//
// boxes load one per cycle while the block is idle; after the last box it ranks them:
// for each box it reads and latches its own score (rk_rdi, rk_ldi), then compares it with
// every box, reading each in turn on the single candidate ram port (rk_rdj, rk_cmp);
// suppression then fetches each candidate (sp_rank, sp_cand, sp_load), passes surv per survivor,
// and checks each survivor-list entry in sp_krd and sp_a, plus sp_b to sp_e for the same class
// reset clears the batch counters, flags and the output valid and restores the registers; rams are not cleared
// output stalls only hold the flow when a survivor or the final result must move to the output

module class_aware_nms_engine (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  cnms_pkg::in_t                             in_data,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output cnms_pkg::out_t                            out_data,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [cnms_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [cnms_pkg::CFG_DAT_W-1:0]            cfg_data
);

	import cnms_pkg::*;

	state_t state_q, state_d;

	// batch bookkeeping
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [7:0]        thr_q;
	logic [6:0]        maxo_q;
	logic [KCNT_W-1:0] lim;

	// ranking counters
	logic [CNT_W-1:0]  i_q, j_q, pos_q, pos_nx;
	logic [15:0]       si_q;
	logic              beats;

	// suppression walk
	logic [CNT_W-1:0]  r_q;
	logic [IDX_W-1:0]  a_q;
	cand_t             c_q;
	logic [KCNT_W-1:0] k_q, kcnt_q;

	// overlap pipeline
	logic [11:0] dx_s1, dy_s1, wp_s1, hp_s1, wq_s1, hq_s1;
	logic [23:0] inter_s2, ap_s2, aq_s2;
	logic [23:0] inter_s3, uni_s3;
	logic [31:0] inter_s4, prod_s4;
	logic        upos_s4;

	// survivor waiting for its last flag
	cand_t            pend_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             pend_v_q;

	out_t out_q;
	logic out_v_q;
	logic out_free;
	logic out_load;

	// ram ports
	logic             cand_we;
	logic [IDX_W-1:0] cand_waddr, cand_raddr;
	cand_t            cand_wdata;
	logic [$bits(cand_t)-1:0] cand_rbits;
	cand_t            cand_rd;
	logic             rank_we;
	logic [IDX_W-1:0] rank_waddr, rank_raddr, rank_rd;
	logic             kept_we;
	logic [KA_W-1:0]  kept_addr_w, kept_raddr;
	logic [$bits(cand_t)-1:0] kept_rbits;
	cand_t            kept_rd;

	logic in_acc;
	logic j_last, r_last, k_last, hit;

	// geometry of the survivor (p) against the candidate (q)
	logic signed [13:0] px0, px1, py0, py1, qx0, qx1, qy0, qy1;
	logic signed [13:0] xlo, xhi, ylo, yhi, dxs, dys;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign out_free  = !out_v_q || !out_stall;
	assign out_load  = (kept_we && pend_v_q) || (state_q == ST_FINISH && out_free);

	assign lim = (maxo_q == 7'd0) ? KCNT_W'(1) :
		((maxo_q > 7'(RESULT_LIMIT)) ? KCNT_W'(RESULT_LIMIT) : KCNT_W'(maxo_q));

	assign cand_rd = cand_t'(cand_rbits);
	assign kept_rd = cand_t'(kept_rbits);

	// stable descending rank: count the boxes that go ahead of box i
	assign beats  = (cand_rd.score > si_q) || ((cand_rd.score == si_q) && (j_q < i_q));
	assign pos_nx = pos_q + CNT_W'(beats);
	assign j_last = (j_q + CNT_W'(1)) == cnt_q;
	assign r_last = (r_q + CNT_W'(1)) == cnt_q;
	assign k_last = (k_q + KCNT_W'(1)) == kcnt_q;
	assign hit    = upos_s4 && (inter_s4 > prod_s4);

	// span overlap with the inclusive pixel convention
	assign px0 = 14'(kept_rd.box.left);
	assign py0 = 14'(kept_rd.box.top);
	assign qx0 = 14'(c_q.box.left);
	assign qy0 = 14'(c_q.box.top);
	assign px1 = px0 + $signed(14'(kept_rd.box.width));
	assign py1 = py0 + $signed(14'(kept_rd.box.height));
	assign qx1 = qx0 + $signed(14'(c_q.box.width));
	assign qy1 = qy0 + $signed(14'(c_q.box.height));
	assign xlo = (px0 > qx0) ? px0 : qx0;
	assign xhi = (px1 < qx1) ? px1 : qx1;
	assign ylo = (py0 > qy0) ? py0 : qy0;
	assign yhi = (py1 < qy1) ? py1 : qy1;
	assign dxs = xhi - xlo + 14'sd1;
	assign dys = yhi - ylo + 14'sd1;

	always_comb begin
		cand_wdata.box.left   = in_data.box_left;
		cand_wdata.box.top    = in_data.box_top;
		cand_wdata.box.width  = in_data.box_width;
		cand_wdata.box.height = in_data.box_height;
		cand_wdata.box.cls    = in_data.box_class;
		cand_wdata.score      = in_data.score;
	end

	assign cand_we     = in_acc && (cnt_q != CNT_W'(MAX_BOXES));
	assign cand_waddr  = cnt_q[IDX_W-1:0];
	assign rank_we     = (state_q == ST_RK_CMP) && j_last;
	assign rank_waddr  = pos_nx[IDX_W-1:0];
	assign rank_raddr  = r_q[IDX_W-1:0];
	assign kept_we     = (state_q == ST_SURV) && !(pend_v_q && !out_free);
	assign kept_addr_w = kcnt_q[KA_W-1:0];
	assign kept_raddr  = k_q[KA_W-1:0];

	always_comb begin
		unique case (state_q)
			ST_RK_RDI:  cand_raddr = i_q[IDX_W-1:0];
			ST_SP_CAND: cand_raddr = rank_rd;
			default:    cand_raddr = j_q[IDX_W-1:0];
		endcase
	end

	cnms_ram #(.WIDTH($bits(cand_t)), .DEPTH(MAX_BOXES)) u_cand_ram (
		.clk   (clk),
		.we    (cand_we),
		.waddr (cand_waddr),
		.wdata (cand_wdata),
		.raddr (cand_raddr),
		.rdata (cand_rbits)
	);

	cnms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (i_q[IDX_W-1:0]),
		.raddr (rank_raddr),
		.rdata (rank_rd)
	);

	// survivors found so far, the only boxes that can still suppress
	cnms_ram #(.WIDTH($bits(cand_t)), .DEPTH(RESULT_LIMIT)) u_kept_ram (
		.clk   (clk),
		.we    (kept_we),
		.waddr (kept_addr_w),
		.wdata (c_q),
		.raddr (kept_raddr),
		.rdata (kept_rbits)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_data.last_box) state_d = ST_RK_RDI;
			end
			ST_RK_RDI: state_d = ST_RK_LDI;
			ST_RK_LDI: state_d = ST_RK_RDJ;
			ST_RK_RDJ: state_d = ST_RK_CMP;
			ST_RK_CMP: begin
				if (!j_last) state_d = ST_RK_RDJ;
				else if ((i_q + CNT_W'(1)) == cnt_q) state_d = ST_SP_RANK;
				else state_d = ST_RK_RDI;
			end
			ST_SP_RANK: state_d = ST_SP_CAND;
			ST_SP_CAND: state_d = ST_SP_LOAD;
			ST_SP_LOAD: state_d = (kcnt_q == '0) ? ST_SURV : ST_SP_KRD;
			ST_SP_KRD:  state_d = ST_SP_A;
			ST_SP_A: begin
				if (kept_rd.box.cls == c_q.box.cls) state_d = ST_SP_B;
				else if (k_last) state_d = ST_SURV;
				else state_d = ST_SP_KRD;
			end
			ST_SP_B: state_d = ST_SP_C;
			ST_SP_C: state_d = ST_SP_D;
			ST_SP_D: state_d = ST_SP_E;
			ST_SP_E: begin
				if (hit) state_d = r_last ? ST_FINISH : ST_SP_RANK;
				else if (k_last) state_d = ST_SURV;
				else state_d = ST_SP_KRD;
			end
			ST_SURV: begin
				if (!(pend_v_q && !out_free)) begin
					if ((kcnt_q + KCNT_W'(1)) == lim || r_last) state_d = ST_FINISH;
					else state_d = ST_SP_RANK;
				end
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and batch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			maxo_q   <= MAX_OUT_RESET;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			kcnt_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IOU_THRESHOLD: thr_q  <= cfg_data[7:0];
					CFG_MAX_OUT:       maxo_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (cand_we) cnt_q <= cnt_q + CNT_W'(1);
				else ovf_q <= 1'b1;
			end
			// a new transaction loads, or the accepted one leaves
			if (out_load) out_v_q <= 1'b1;
			else if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (kept_we) begin
				kcnt_q   <= kcnt_q + KCNT_W'(1);
				pend_v_q <= 1'b1;
			end
			if (state_q == ST_FINISH && out_free) begin
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
				kcnt_q   <= '0;
				pend_v_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				i_q <= '0;
				r_q <= '0;
			end
			ST_RK_LDI: begin
				si_q  <= cand_rd.score;
				j_q   <= '0;
				pos_q <= '0;
			end
			ST_RK_CMP: begin
				pos_q <= pos_nx;
				j_q   <= j_q + CNT_W'(1);
				if (j_last) i_q <= i_q + CNT_W'(1);
			end
			ST_SP_CAND: a_q <= rank_rd;
			ST_SP_LOAD: begin
				c_q <= cand_rd;
				k_q <= '0;
			end
			ST_SP_A: begin
				dx_s1 <= (dxs > 14'sd0) ? 12'(dxs) : 12'd0;
				dy_s1 <= (dys > 14'sd0) ? 12'(dys) : 12'd0;
				wp_s1 <= 12'(kept_rd.box.width) + 12'd1;
				hp_s1 <= 12'(kept_rd.box.height) + 12'd1;
				wq_s1 <= 12'(c_q.box.width) + 12'd1;
				hq_s1 <= 12'(c_q.box.height) + 12'd1;
				if (kept_rd.box.cls != c_q.box.cls) k_q <= k_q + KCNT_W'(1);
			end
			ST_SP_B: begin
				inter_s2 <= dx_s1 * dy_s1;
				ap_s2    <= wp_s1 * hp_s1;
				aq_s2    <= wq_s1 * hq_s1;
			end
			ST_SP_C: begin
				inter_s3 <= inter_s2;
				uni_s3   <= ap_s2 + aq_s2 - inter_s2;
			end
			ST_SP_D: begin
				inter_s4 <= {inter_s3, 8'd0};
				prod_s4  <= thr_q * uni_s3;
				upos_s4  <= (uni_s3 != 24'd0);
			end
			ST_SP_E: begin
				k_q <= k_q + KCNT_W'(1);
				if (hit) r_q <= r_q + CNT_W'(1);
			end
			ST_SURV: begin
				if (kept_we) begin
					pend_q     <= c_q;
					pend_idx_q <= a_q;
					r_q        <= r_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// output register: a survivor leaves once the next one is known or the batch ends
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.kept_index   <= pend_v_q ? 8'(pend_idx_q) : 8'd0;
			out_q.kept_left    <= pend_v_q ? pend_q.box.left : 12'sd0;
			out_q.kept_top     <= pend_v_q ? pend_q.box.top : 12'sd0;
			out_q.kept_width   <= pend_v_q ? pend_q.box.width : 11'd0;
			out_q.kept_height  <= pend_v_q ? pend_q.box.height : 11'd0;
			out_q.kept_class   <= pend_v_q ? pend_q.box.cls : 7'd0;
			out_q.kept_score   <= pend_v_q ? pend_q.score : 16'd0;
			out_q.none_kept    <= !pend_v_q;
			out_q.dropped_some <= ovf_q;
			out_q.last_result  <= (state_q == ST_FINISH);
		end
	end

endmodule

/* rtl/core/cnms_ram.sv */
module cnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/cnms_checker.sv */
module cnms_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input cnms_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input cnms_pkg::out_t out_data
);

	import cnms_pkg::*;

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// the batch closes after its last box
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last_box |=> in_stall)
		else $error("block not busy after last box");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.none_kept |-> out_data.last_result)
		else $error("none-kept result not last");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.none_kept |-> out_data.kept_score == 16'd0 &&
		out_data.kept_width == 11'd0 && out_data.kept_index == 8'd0)
		else $error("none-kept result carries data");

endmodule

bind class_aware_nms_engine cnms_checker u_cnms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import cnms_pkg::*;

	// dut signals
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	class_aware_nms_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	localparam int IDLE_LIMIT = 1000000;
	localparam int ITEM_GOAL  = 450;
	localparam int LONG_HOLD  = 600;

	// candidates waiting to be offered, and survivors the batch should yield
	in_t  box_queue[$];
	out_t kept_due[$];

	// shadow copy of the block's batch state and registers
	in_t         box_mem [MAX_BOXES];
	int          rank_ord[MAX_BOXES];
	bit          gone    [MAX_BOXES];
	int          box_cnt;
	bit          store_ovf;
	logic [7:0]  thr_q8;
	logic [6:0]  max_keep;

	int err_cnt;
	int items_sent;
	bit idle_on;      // random gaps on both sides when set
	int send_wait;
	int stall_wait;
	int hold_cnt;
	bit hold_req;
	bit hold_done;
	int quiet_cnt;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp);
		err_cnt++;
	endtask

	// inclusive +1 pixel span overlap
	function automatic longint span_common(longint a0, longint a1, longint b0, longint b1);
		longint lo, hi;
		lo = a0 > b0 ? a0 : b0;
		hi = a1 < b1 ? a1 : b1;
		return (hi - lo + 1) > 0 ? hi - lo + 1 : 0;
	endfunction

	function automatic bit iou_over(in_t p, in_t q);
		longint px, py, qx, qy, pw, ph, qw, qh, inter, uni;
		px = p.box_left;  py = p.box_top;
		qx = q.box_left;  qy = q.box_top;
		pw = p.box_width; ph = p.box_height;
		qw = q.box_width; qh = q.box_height;
		inter = span_common(px, px + pw, qx, qx + qw) * span_common(py, py + ph, qy, qy + qh);
		uni = (pw + 1) * (ph + 1) + (qw + 1) * (qh + 1) - inter;
		if (uni <= 0)
			return 0;
		return inter * 256 > longint'(thr_q8) * uni;
	endfunction

	// takes one accepted candidate; on the batch's last box ranks, suppresses
	// and queues the survivors
	function automatic void nms_take_box(in_t b);
		int   i, j, a, c, lim;
		out_t r;
		out_t batch_out[$];
		if (box_cnt < MAX_BOXES) begin
			box_mem[box_cnt] = b;
			gone[box_cnt] = 0;
			box_cnt++;
		end else begin
			store_ovf = 1;
		end
		if (!b.last_box)
			return;
		// stable ranking, highest score first
		for (i = 0; i < box_cnt; i++) begin
			j = i;
			while (j > 0 && box_mem[rank_ord[j-1]].score < box_mem[i].score) begin
				rank_ord[j] = rank_ord[j-1];
				j--;
			end
			rank_ord[j] = i;
		end
		// greedy class-aware suppression
		for (i = 0; i < box_cnt; i++) begin
			a = rank_ord[i];
			if (gone[a])
				continue;
			for (j = i + 1; j < box_cnt; j++) begin
				c = rank_ord[j];
				if (gone[c] || box_mem[a].box_class != box_mem[c].box_class)
					continue;
				if (iou_over(box_mem[a], box_mem[c]))
					gone[c] = 1;
			end
		end
		lim = max_keep == 0 ? 1 : (max_keep > RESULT_LIMIT ? RESULT_LIMIT : max_keep);
		for (i = 0; i < box_cnt && batch_out.size() < lim; i++) begin
			a = rank_ord[i];
			if (gone[a])
				continue;
			r = '0;
			r.kept_index   = a[7:0];
			r.kept_left    = box_mem[a].box_left;
			r.kept_top     = box_mem[a].box_top;
			r.kept_width   = box_mem[a].box_width;
			r.kept_height  = box_mem[a].box_height;
			r.kept_class   = box_mem[a].box_class;
			r.kept_score   = box_mem[a].score;
			r.dropped_some = store_ovf;
			batch_out = {batch_out, r};
		end
		if (batch_out.size() == 0) begin
			r = '0;
			r.none_kept    = 1;
			r.dropped_some = store_ovf;
			batch_out = {batch_out, r};
		end
		batch_out[batch_out.size() - 1].last_result = 1;
		foreach (batch_out[k])
			kept_due = {kept_due, batch_out[k]};
		box_cnt = 0;
		store_ovf = 0;
		for (i = 0; i < MAX_BOXES; i++)
			gone[i] = 0;
	endfunction

	// driver: front of box_queue is what is on the bus; popped on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_data   <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				nms_take_box(in_data);
				void'(box_queue.pop_front());
				send_wait = idle_on ? $urandom_range(0, 10) : 0;
			end
			if (in_valid && in_stall) begin
				// stalled transaction stays on the bus unchanged
			end else if (send_wait > 0) begin
				send_wait = send_wait - 1;
				in_valid <= 1'b0;
			end else if (box_queue.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= box_queue[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_done <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req && !hold_done) begin
			hold_cnt  <= LONG_HOLD;
			hold_done <= 1;
		end
	end

	// monitor: checks each survivor against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_wait <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (kept_due.size() == 0) begin
					report_mismatch("result with none pending, index", out_data.kept_index, 0);
				end else begin
					automatic out_t e = kept_due.pop_front();
					if (out_data.kept_index != e.kept_index)
						report_mismatch("kept_index", out_data.kept_index, e.kept_index);
					if (out_data.kept_left != e.kept_left)
						report_mismatch("kept_left", out_data.kept_left, e.kept_left);
					if (out_data.kept_top != e.kept_top)
						report_mismatch("kept_top", out_data.kept_top, e.kept_top);
					if (out_data.kept_width != e.kept_width)
						report_mismatch("kept_width", out_data.kept_width, e.kept_width);
					if (out_data.kept_height != e.kept_height)
						report_mismatch("kept_height", out_data.kept_height, e.kept_height);
					if (out_data.kept_class != e.kept_class)
						report_mismatch("kept_class", out_data.kept_class, e.kept_class);
					if (out_data.kept_score != e.kept_score)
						report_mismatch("kept_score", out_data.kept_score, e.kept_score);
					if (out_data.none_kept != e.none_kept)
						report_mismatch("none_kept", out_data.none_kept, e.none_kept);
					if (out_data.dropped_some != e.dropped_some)
						report_mismatch("dropped_some", out_data.dropped_some, e.dropped_some);
					if (out_data.last_result != e.last_result)
						report_mismatch("last_result", out_data.last_result, e.last_result);
				end
				stall_wait = idle_on ? $urandom_range(0, 10) : 0;
			end else if (stall_wait > 0) begin
				stall_wait = stall_wait - 1;
			end
			out_stall <= (hold_cnt > 0) || (stall_wait > 0);
		end
	end

	// register writes land in the shadow copy
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_IOU_THRESHOLD)
				thr_q8 = cfg_data;
			else if (cfg_index == CFG_MAX_OUT)
				max_keep = cfg_data[6:0];
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= IDLE_LIMIT) begin
			$display("class_aware_nms_engine test failed");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	task automatic add_box(input int l, input int t, input int w, input int h,
		input int c, input int s, input bit last);
		in_t b;
		b.box_left   = l[11:0];
		b.box_top    = t[11:0];
		b.box_width  = w[10:0];
		b.box_height = h[10:0];
		b.box_class  = c[6:0];
		b.score      = s[15:0];
		b.last_box   = last;
		box_queue = {box_queue, b};
		items_sent++;
	endtask

	// sender holds until every survivor is back, then lets the block settle
	task automatic drain;
		do @(posedge clk);
		while (box_queue.size() > 0 || in_valid || kept_due.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[7:0];
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	function automatic int clamp12(int v);
		return v > 2047 ? 2047 : (v < -2048 ? -2048 : v);
	endfunction

	// batch of boxes clustered around one center, with some fully random ones
	task automatic random_batch(input int n);
		int cx, cy, ncls, sc_base;
		cx = $urandom_range(0, 3600) - 1800;
		cy = $urandom_range(0, 3600) - 1800;
		ncls = $urandom_range(1, 4);
		sc_base = $urandom_range(0, 65535);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				add_box($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
					$urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 127), $urandom_range(0, 65535), i == n - 1);
			else
				add_box(clamp12(cx + $urandom_range(0, 40) - 20),
					clamp12(cy + $urandom_range(0, 40) - 20),
					$urandom_range(20, 120), $urandom_range(20, 120),
					$urandom_range(0, ncls - 1) * 37,
					$urandom_range(0, 3) == 0 ? sc_base : $urandom_range(0, 65535),
					i == n - 1);
		end
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		thr_q8    = THR_RESET;
		max_keep  = MAX_OUT_RESET;
		box_cnt   = 0;
		store_ovf = 0;
		err_cnt   = 0;
		items_sent = 0;
		idle_on   = 0;
		hold_req  = 0;
		quiet_cnt = 0;
		foreach (gone[i])
			gone[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single box at the corner extremes, reset registers
		add_box(-2048, -2048, 2047, 2047, 127, 65535, 1);
		add_box(2047, 2047, 0, 0, 0, 0, 1);
		// identical boxes same class: second suppressed; other class survives
		add_box(100, 100, 50, 50, 5, 40000, 0);
		add_box(100, 100, 50, 50, 5, 30000, 0);
		add_box(100, 100, 50, 50, 6, 20000, 1);
		// equal scores keep arrival order, disjoint boxes
		add_box(0, 0, 10, 10, 1, 777, 0);
		add_box(500, 500, 10, 10, 1, 777, 0);
		add_box(-500, -500, 10, 10, 1, 777, 1);
		drain();

		// threshold zero: any touching box of a class is suppressed
		write_reg(CFG_IOU_THRESHOLD, 0);
		write_reg(CFG_MAX_OUT, 0);   // acts as one
		add_box(0, 0, 0, 0, 3, 100, 0);
		add_box(0, 0, 0, 0, 3, 200, 0);
		add_box(10, 10, 5, 5, 3, 300, 1);
		drain();
		write_reg(CFG_MAX_OUT, 127); // clipped to the result limit
		write_reg(CFG_IOU_THRESHOLD, 255);
		add_box(0, 0, 0, 0, 3, 100, 0);
		add_box(0, 0, 0, 0, 3, 200, 0);
		add_box(0, 0, 1, 0, 3, 50, 1);
		drain();

		// store overflow: last box arrives with the store full
		write_reg(CFG_MAX_OUT, 64);
		write_reg(CFG_IOU_THRESHOLD, THR_RESET);
		for (int i = 0; i < MAX_BOXES + 2; i++)
			add_box(($urandom_range(0, 4095)) - 2048, $urandom_range(0, 4095) - 2048,
				$urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 127),
				$urandom_range(0, 65535), i == MAX_BOXES + 1);
		drain();

		// long output hold-off while the next batch is offered behind it
		idle_on = 1;
		for (int i = 0; i < 12; i++)
			add_box(i * 100, 0, 30, 30, i, 1000 + i, i == 11);
		random_batch(8);
		hold_req <= 1'b1;
		drain();

		// random phases with different register settings
		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(0, 3))
				0: write_reg(CFG_IOU_THRESHOLD, $urandom_range(0, 255));
				1: write_reg(CFG_MAX_OUT, $urandom_range(1, 64));
				2: write_reg(CFG_MAX_OUT, $urandom_range(1, 4));
				default: write_reg(CFG_IOU_THRESHOLD, $urandom_range(60, 180));
			endcase
			idle_on = $urandom_range(0, 3) != 0;
			for (int k = 0; k < 4; k++)
				random_batch($urandom_range(1, 10));
			drain();
		end

		if (err_cnt == 0)
			$display("class_aware_nms_engine test passed");
		else
			$display("class_aware_nms_engine test failed");
		$finish;
	end

endmodule
